@@ rtl/core/dacp_pkg.sv @@
package dacp_pkg;

   // chunk and value geometry
   localparam int CHUNK_BYTES      = 8;
   localparam int VALUE_BITS       = 64;
   localparam int HALF_BITS        = VALUE_BITS / 2;
   localparam int CHAR_BITS        = 8;
   localparam int DIGIT_BITS       = 4;
   localparam int COUNT_BITS       = 4;
   localparam int CHUNK_VALUE_BITS = 27;
   localparam int POW5_BITS        = 19;
   localparam int PAIR_COUNT       = CHUNK_BYTES / 2;
   localparam int NUM_STAGES       = 5;

   // bus widths
   localparam int REQ_DATA_BITS = ((CHUNK_BYTES * CHAR_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((VALUE_BITS + COUNT_BITS + 7) / 8) * 8;

   // ascii digit bounds
   localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 8'h30;
   localparam logic [CHAR_BITS-1:0] ASCII_NINE = 8'h39;

   typedef logic [CHUNK_VALUE_BITS-1:0] chunk_value_type;

   // pipeline load enables for the lane, weight, pair-sum and chunk-sum registers; the accumulate stage loads on take
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_load_type;

   // parsed chunk handed to the accumulator
   typedef struct packed {
      logic                  start;
      logic [COUNT_BITS-1:0] count;
      chunk_value_type       chunk;
   } chunk_info_type;

   function automatic chunk_value_type pow10(input logic [COUNT_BITS-1:0] power);
      chunk_value_type result;
      unique case (power)
         4'd0:    result = 27'd1;
         4'd1:    result = 27'd10;
         4'd2:    result = 27'd100;
         4'd3:    result = 27'd1000;
         4'd4:    result = 27'd10000;
         4'd5:    result = 27'd100000;
         4'd6:    result = 27'd1000000;
         4'd7:    result = 27'd10000000;
         default: result = '0;
      endcase
      return result;
   endfunction

   // 10^k is 5^k shifted left by k
   function automatic logic [POW5_BITS-1:0] pow5(input logic [COUNT_BITS-1:0] power);
      logic [POW5_BITS-1:0] result;
      unique case (power)
         4'd0:    result = 19'd1;
         4'd1:    result = 19'd5;
         4'd2:    result = 19'd25;
         4'd3:    result = 19'd125;
         4'd4:    result = 19'd625;
         4'd5:    result = 19'd3125;
         4'd6:    result = 19'd15625;
         4'd7:    result = 19'd78125;
         4'd8:    result = 19'd390625;
         default: result = '0;
      endcase
      return result;
   endfunction

endpackage

@@ rtl/core/dacp_lane.sv @@
module dacp_lane #(
   parameter int LANE_INDEX = 0
) (
   input  logic                                clock,
   input  dacp_pkg::stage_load_type            load,
   input  logic [dacp_pkg::CHAR_BITS-1:0]      char_byte,
   input  logic [dacp_pkg::COUNT_BITS-1:0]     run_count,
   output logic                                is_digit,
   output dacp_pkg::chunk_value_type           term
);

   logic                                is_digit_ff, is_digit_in;
   logic [dacp_pkg::DIGIT_BITS-1:0]     digit_ff, digit_in;
   dacp_pkg::chunk_value_type           term_ff, term_in;
   logic [dacp_pkg::COUNT_BITS-1:0]     lane_pos;
   logic [dacp_pkg::COUNT_BITS-1:0]     power;
   logic                                in_run;

   // stage 1: classify the byte
   assign is_digit_in = (char_byte >= dacp_pkg::ASCII_ZERO) &&
                        (char_byte <= dacp_pkg::ASCII_NINE);
   assign digit_in    = dacp_pkg::DIGIT_BITS'(char_byte - dacp_pkg::ASCII_ZERO);

   // stage 2: weight by place within the leading run
   assign lane_pos = dacp_pkg::COUNT_BITS'(LANE_INDEX);
   assign in_run   = lane_pos < run_count;
   assign power    = run_count - lane_pos - dacp_pkg::COUNT_BITS'(1);
   assign term_in  = in_run ?
      dacp_pkg::CHUNK_VALUE_BITS'(dacp_pkg::CHUNK_VALUE_BITS'(digit_ff) *
                                  dacp_pkg::pow10(power)) : '0;

   always_ff @(posedge clock) begin
      if (load.s1) begin
         is_digit_ff <= is_digit_in;
         digit_ff    <= digit_in;
      end
      if (load.s2) begin
         term_ff <= term_in;
      end
   end

   assign is_digit = is_digit_ff;
   assign term     = term_ff;

endmodule

@@ rtl/core/dacp_merge.sv @@
module dacp_merge (
   input  logic                                  clock,
   input  dacp_pkg::stage_load_type              load,
   input  logic                                  start_s1,
   input  logic [dacp_pkg::CHUNK_BYTES-1:0]      lane_digit,
   input  dacp_pkg::chunk_value_type             lane_term [dacp_pkg::CHUNK_BYTES],
   output logic [dacp_pkg::COUNT_BITS-1:0]       run_count,
   output dacp_pkg::chunk_info_type              info
);

   logic                              start_s2_ff, start_s2_in;
   logic [dacp_pkg::COUNT_BITS-1:0]   count_s2_ff, count_s2_in;
   logic                              start_s3_ff, start_s3_in;
   logic [dacp_pkg::COUNT_BITS-1:0]   count_s3_ff, count_s3_in;
   dacp_pkg::chunk_value_type         pair_ff [dacp_pkg::PAIR_COUNT];
   dacp_pkg::chunk_value_type         pair_in [dacp_pkg::PAIR_COUNT];
   dacp_pkg::chunk_info_type          info_ff, info_in;
   dacp_pkg::chunk_value_type         chunk_sum;

   // length of the leading digit run
   always_comb begin
      logic found;
      found     = 1'b0;
      run_count = dacp_pkg::COUNT_BITS'(dacp_pkg::CHUNK_BYTES);
      for (int i = 0; i < dacp_pkg::CHUNK_BYTES; i++) begin
         if (!found && !lane_digit[i]) begin
            run_count = dacp_pkg::COUNT_BITS'(i);
            found     = 1'b1;
         end
      end
   end

   assign start_s2_in = start_s1;
   assign count_s2_in = run_count;
   assign start_s3_in = start_s2_ff;
   assign count_s3_in = count_s2_ff;

   // first level of the sum tree
   always_comb begin
      for (int p = 0; p < dacp_pkg::PAIR_COUNT; p++) begin
         pair_in[p] = lane_term[2*p] + lane_term[2*p+1];
      end
   end

   // second level
   always_comb begin
      chunk_sum = '0;
      for (int p = 0; p < dacp_pkg::PAIR_COUNT; p++) begin
         chunk_sum = chunk_sum + pair_ff[p];
      end
   end

   assign info_in.start = start_s3_ff;
   assign info_in.count = count_s3_ff;
   assign info_in.chunk = chunk_sum;

   always_ff @(posedge clock) begin
      if (load.s2) begin
         start_s2_ff <= start_s2_in;
         count_s2_ff <= count_s2_in;
      end
      if (load.s3) begin
         start_s3_ff <= start_s3_in;
         count_s3_ff <= count_s3_in;
         pair_ff     <= pair_in;
      end
      if (load.s4) begin
         info_ff <= info_in;
      end
   end

   assign info = info_ff;

endmodule

@@ rtl/core/dacp_accum.sv @@
module dacp_accum (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               take,
   input  dacp_pkg::chunk_info_type           info,
   output logic [dacp_pkg::VALUE_BITS-1:0]    value,
   output logic [dacp_pkg::COUNT_BITS-1:0]    digit_count,
   output logic                               number_ended
);

   localparam int PROD_BITS = dacp_pkg::HALF_BITS + dacp_pkg::POW5_BITS;

   logic [dacp_pkg::VALUE_BITS-1:0]   acc_ff, acc_in;
   logic                              ended_ff, ended_in;
   logic [dacp_pkg::COUNT_BITS-1:0]   count_ff, count_in;
   logic [dacp_pkg::VALUE_BITS-1:0]   base;
   logic                              ended_base;
   logic [dacp_pkg::POW5_BITS-1:0]    scale5;
   logic [PROD_BITS-1:0]              lo_prod;
   logic [PROD_BITS-1:0]              hi_prod;
   logic [dacp_pkg::VALUE_BITS-1:0]   prod5;
   logic [dacp_pkg::VALUE_BITS-1:0]   scaled;

   // start clears the number ahead of this chunk
   assign base       = info.start ? '0 : acc_ff;
   assign ended_base = info.start ? 1'b0 : ended_ff;

   // base * 5^count modulo 2^64 from two half-width products
   assign scale5  = dacp_pkg::pow5(info.count);
   assign lo_prod = PROD_BITS'(base[dacp_pkg::HALF_BITS-1:0]) * PROD_BITS'(scale5);
   assign hi_prod = PROD_BITS'(base[dacp_pkg::VALUE_BITS-1:dacp_pkg::HALF_BITS]) *
                    PROD_BITS'(scale5);
   assign prod5   = {hi_prod[dacp_pkg::HALF_BITS-1:0], dacp_pkg::HALF_BITS'(0)} +
                    dacp_pkg::VALUE_BITS'(lo_prod);
   assign scaled  = prod5 << info.count;

   always_comb begin
      if (ended_base) begin
         acc_in   = base;
         count_in = '0;
         ended_in = 1'b1;
      end else begin
         acc_in   = scaled + dacp_pkg::VALUE_BITS'(info.chunk);
         count_in = info.count;
         ended_in = info.count != dacp_pkg::COUNT_BITS'(dacp_pkg::CHUNK_BYTES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         ended_ff <= 1'b0;
      end else if (take) begin
         acc_ff   <= acc_in;
         ended_ff <= ended_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         count_ff <= count_in;
      end
   end

   assign value        = acc_ff;
   assign digit_count  = count_ff;
   assign number_ended = ended_ff;

endmodule

@@ rtl/core/decimal_ascii_chunk_parser_unit.sv @@
// decimal text parser: each request transaction carries eight ascii bytes, char_0 in the
// lowest byte of req_tdata, and a start flag in req_tuser that clears the running number
// before the chunk is parsed. eight byte lanes classify and weight the leading run of
// digits, a two-level adder tree merges them into a chunk value, and the accumulate
// stage folds it in as value * 10^count + chunk, wrapping modulo 2^64. once a non-digit
// has ended a number, later chunks add nothing until the next start. every request
// gives exactly one response transaction, in order. the block takes one transaction
// per clock while req_tready is high, through the lane, weight, pair-sum, chunk-sum
// and accumulate registers to rsp_tvalid; the rate is set by the accumulate stage,
// whose feedback through two 32 x 19 multipliers, a 64-bit add, a shift and a final
// add has no register inside it. each stage holds its item until the next one frees
// up, so bubbles are squeezed out and requests fill empty stages while rsp_tready is low.
module decimal_ascii_chunk_parser_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [dacp_pkg::REQ_DATA_BITS-1:0]     req_tdata,  // char_0 .. char_7, 8 bits each
   input  logic                                   req_tuser,  // start_number
   // response channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [dacp_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,  // value[63:0], digit_count[67:64]
   output logic                                   rsp_tuser   // number_ended
);

   localparam int LAST_STAGE = dacp_pkg::NUM_STAGES - 1;

   // stage valid flags: lanes, weights, pair sums, chunk sum, accumulate/output
   logic [dacp_pkg::NUM_STAGES-1:0]      valid_ff, valid_in;
   logic [dacp_pkg::NUM_STAGES-1:0]      stage_ready;
   dacp_pkg::stage_load_type             load;
   logic                                 acc_take;
   logic                                 start_s1_ff, start_s1_in;

   logic [dacp_pkg::CHUNK_BYTES-1:0]     lane_digit;
   dacp_pkg::chunk_value_type            lane_term [dacp_pkg::CHUNK_BYTES];
   logic [dacp_pkg::COUNT_BITS-1:0]      run_count;
   dacp_pkg::chunk_info_type             info;

   logic [dacp_pkg::VALUE_BITS-1:0]      value;
   logic [dacp_pkg::COUNT_BITS-1:0]      digit_count;
   logic                                 number_ended;

   // a stage can load when it is empty or its content moves on this cycle
   always_comb begin
      stage_ready[LAST_STAGE] = !valid_ff[LAST_STAGE] || rsp_tready;
      for (int k = LAST_STAGE - 1; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   always_comb begin
      valid_in[0] = stage_ready[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < dacp_pkg::NUM_STAGES; k++) begin
         valid_in[k] = stage_ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign load.s1 = stage_ready[0];
   assign load.s2 = stage_ready[1];
   assign load.s3 = stage_ready[2];
   assign load.s4 = stage_ready[3];

   // the accumulator only moves on a real item, never on a bubble
   assign acc_take = stage_ready[LAST_STAGE] && valid_ff[LAST_STAGE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign start_s1_in = req_tuser;

   always_ff @(posedge clock) begin
      if (load.s1) begin
         start_s1_ff <= start_s1_in;
      end
   end

   // one lane per text byte
   for (genvar lane = 0; lane < dacp_pkg::CHUNK_BYTES; lane++) begin : g_lane
      dacp_lane #(
         .LANE_INDEX (lane)
      ) u_lane (
         .clock     (clock),
         .load      (load),
         .char_byte (req_tdata[lane*dacp_pkg::CHAR_BITS +: dacp_pkg::CHAR_BITS]),
         .run_count (run_count),
         .is_digit  (lane_digit[lane]),
         .term      (lane_term[lane])
      );
   end

   // run length and sum of the lane terms
   dacp_merge u_merge (
      .clock      (clock),
      .load       (load),
      .start_s1   (start_s1_ff),
      .lane_digit (lane_digit),
      .lane_term  (lane_term),
      .run_count  (run_count),
      .info       (info)
   );

   // running number; its registers double as the response register
   dacp_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .take         (acc_take),
      .info         (info),
      .value        (value),
      .digit_count  (digit_count),
      .number_ended (number_ended)
   );

   assign req_tready = stage_ready[0];
   assign rsp_tvalid = valid_ff[LAST_STAGE];
   assign rsp_tdata  = dacp_pkg::RSP_DATA_BITS'({digit_count, value});
   assign rsp_tuser  = number_ended;

endmodule

@@ rtl/core/dacp_checker.sv @@
module dacp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [dacp_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input logic                                 rsp_tuser
);

   localparam logic [dacp_pkg::COUNT_BITS-1:0] FULL_COUNT =
      dacp_pkg::COUNT_BITS'(dacp_pkg::CHUNK_BYTES);

   logic [dacp_pkg::COUNT_BITS-1:0] rsp_count;

   assign rsp_count = rsp_tdata[dacp_pkg::VALUE_BITS +: dacp_pkg::COUNT_BITS];

   // a digit_count short of a full chunk always comes with the number ended, and a full count never does
   a_ended_matches_count : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == (rsp_count != FULL_COUNT)))
      else $error("number_ended disagrees with digit_count");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_count <= FULL_COUNT))
      else $error("digit_count beyond chunk size");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // pipeline is empty and open right after reset
   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

endmodule

bind decimal_ascii_chunk_parser_unit dacp_checker u_dacp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ tb/decimal_ascii_chunk_parser_unit_tb.sv @@
`timescale 1ns / 100ps

module decimal_ascii_chunk_parser_unit_tb;

   // stimulus sizing and handshake pressure
   localparam int RANDOM_CHUNKS  = 1200;
   localparam int IDLE_PERCENT   = 13;
   localparam int QUIET_FIRST    = 500;   // no idling on either side in this window
   localparam int QUIET_LAST     = 700;
   localparam int HOLD_AT        = 200;   // response count that triggers the long hold-off
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_AT_A     = 420;   // items that wait for every response first
   localparam int DRAIN_AT_B     = 950;
   localparam int SETTLE_CYCLES  = 12;    // covers the five-stage pipeline, with margin
   localparam int WATCHDOG_LIMIT = 4000;

   // one text chunk waiting to be sent
   typedef struct {
      logic [dacp_pkg::REQ_DATA_BITS-1:0] text;
      logic                               start;
      logic                               drain_first;
   } text_chunk_type;

   // what one response transaction should carry
   typedef struct packed {
      logic [dacp_pkg::VALUE_BITS-1:0] value;
      logic [dacp_pkg::COUNT_BITS-1:0] digits;
      logic                            ended;
   } parse_result_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [dacp_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;   // char_0 .. char_7, 8 bits each
   logic                               req_tuser = 1'b0;  // start_number
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [dacp_pkg::RSP_DATA_BITS-1:0] rsp_tdata;         // value, digit_count, zero fill
   logic                               rsp_tuser;         // number_ended

   text_chunk_type   pending_chunks[$];
   parse_result_type expected_results[$];

   // predictor copy of the running number
   logic [dacp_pkg::VALUE_BITS-1:0] running_value = '0;
   logic                            number_closed = 1'b0;

   int chunks_sent    = 0;
   int responses_seen = 0;
   int error_count    = 0;
   int idle_cycles    = 0;

   decimal_ascii_chunk_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // folds one chunk into the running number and returns the response it should give
   function automatic parse_result_type predict_parse(
      input logic [dacp_pkg::REQ_DATA_BITS-1:0] text,
      input logic start);
      parse_result_type                result;
      logic [dacp_pkg::VALUE_BITS-1:0] chunk_value;
      logic [dacp_pkg::VALUE_BITS-1:0] scale;
      logic [dacp_pkg::CHAR_BITS-1:0]  ch;
      logic [dacp_pkg::COUNT_BITS-1:0] digits;
      logic                            run_over;
      chunk_value = '0;
      scale       = 1;
      digits      = '0;
      run_over    = 1'b0;
      if (start) begin
         running_value = '0;
         number_closed = 1'b0;
      end
      // once closed, the chunk is not looked at
      if (!number_closed) begin
         for (int i = 0; i < dacp_pkg::CHUNK_BYTES; i++) begin
            ch = text[dacp_pkg::CHAR_BITS*i +: dacp_pkg::CHAR_BITS];
            if (!run_over && ch >= dacp_pkg::ASCII_ZERO && ch <= dacp_pkg::ASCII_NINE) begin
               chunk_value = chunk_value * 10 + (ch - dacp_pkg::ASCII_ZERO);
               scale       = scale * 10;
               digits      = digits + 1'b1;
            end else begin
               run_over = 1'b1;
            end
         end
         running_value = running_value * scale + chunk_value;
         if (digits < dacp_pkg::CHUNK_BYTES)
            number_closed = 1'b1;
      end
      result.value  = running_value;
      result.digits = digits;
      result.ended  = number_closed;
      return result;
   endfunction

   // packs a short string, first character in the lowest byte, padded with spaces
   function automatic logic [dacp_pkg::REQ_DATA_BITS-1:0] ascii_text(input string s);
      logic [dacp_pkg::REQ_DATA_BITS-1:0] text;
      text = {dacp_pkg::CHUNK_BYTES{8'h20}};
      for (int i = 0; i < s.len() && i < dacp_pkg::CHUNK_BYTES; i++)
         text[dacp_pkg::CHAR_BITS*i +: dacp_pkg::CHAR_BITS] = s[i];
      return text;
   endfunction

   function automatic logic [dacp_pkg::CHAR_BITS-1:0] random_digit();
      return dacp_pkg::ASCII_ZERO + dacp_pkg::CHAR_BITS'($urandom_range(9));
   endfunction

   // any byte outside '0'..'9', with the neighbors of the digit range and the extremes favored
   function automatic logic [dacp_pkg::CHAR_BITS-1:0] random_non_digit();
      logic [dacp_pkg::CHAR_BITS-1:0] ch;
      case ($urandom_range(5))
         0:       ch = dacp_pkg::ASCII_ZERO - 1'b1;
         1:       ch = dacp_pkg::ASCII_NINE + 1'b1;
         2:       ch = 8'h00;
         3:       ch = 8'hFF;
         default: begin
            ch = dacp_pkg::CHAR_BITS'($urandom_range(245));
            if (ch >= dacp_pkg::ASCII_ZERO)
               ch = ch + 8'd10;
         end
      endcase
      return ch;
   endfunction

   // leading run of run_length digits, a non-digit after it, anything beyond
   function automatic logic [dacp_pkg::REQ_DATA_BITS-1:0] text_with_run(input int run_length);
      logic [dacp_pkg::REQ_DATA_BITS-1:0] text;
      for (int i = 0; i < dacp_pkg::CHUNK_BYTES; i++) begin
         if (i < run_length)
            text[dacp_pkg::CHAR_BITS*i +: dacp_pkg::CHAR_BITS] = random_digit();
         else if (i == run_length)
            text[dacp_pkg::CHAR_BITS*i +: dacp_pkg::CHAR_BITS] = random_non_digit();
         else if ($urandom_range(1))
            text[dacp_pkg::CHAR_BITS*i +: dacp_pkg::CHAR_BITS] = random_digit();
         else
            text[dacp_pkg::CHAR_BITS*i +: dacp_pkg::CHAR_BITS] =
               dacp_pkg::CHAR_BITS'($urandom_range(255));
      end
      return text;
   endfunction

   task automatic queue_chunk(input logic [dacp_pkg::REQ_DATA_BITS-1:0] text,
                              input logic start);
      text_chunk_type item;
      item.text        = text;
      item.start       = start;
      item.drain_first = 1'b0;
      pending_chunks.push_back(item);
   endtask

   // request side: presents queued chunks, predicts each one as it is accepted
   always @(posedge clock) begin : request_driver
      text_chunk_type next_chunk;
      logic           quiet;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(predict_parse(req_tdata, req_tuser));
            chunks_sent++;
         end
         if (!req_tvalid || req_tready) begin
            quiet = chunks_sent >= QUIET_FIRST && chunks_sent < QUIET_LAST;
            if (pending_chunks.size() == 0 ||
                (pending_chunks[0].drain_first && expected_results.size() != 0) ||
                (!quiet && $urandom_range(99) < IDLE_PERCENT)) begin
               req_tvalid <= 1'b0;
            end else begin
               next_chunk = pending_chunks.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_chunk.text;
               req_tuser  <= next_chunk.start;
            end
         end
      end
   end

   // response side: checks each transaction, stalls at random and once for a long stretch
   always @(posedge clock) begin : response_monitor
      parse_result_type want;
      int               hold_left;
      logic             quiet;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("response with no request waiting: value %0d",
                      rsp_tdata[dacp_pkg::VALUE_BITS-1:0]);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[dacp_pkg::VALUE_BITS-1:0] !== want.value) begin
                  $error("value mismatch: expected %0d, actual %0d",
                         want.value, rsp_tdata[dacp_pkg::VALUE_BITS-1:0]);
                  error_count++;
               end
               if (rsp_tdata[dacp_pkg::VALUE_BITS +: dacp_pkg::COUNT_BITS] !== want.digits) begin
                  $error("digit_count mismatch: expected %0d, actual %0d",
                         want.digits, rsp_tdata[dacp_pkg::VALUE_BITS +: dacp_pkg::COUNT_BITS]);
                  error_count++;
               end
               if (rsp_tuser !== want.ended) begin
                  $error("number_ended mismatch: expected %0b, actual %0b",
                         want.ended, rsp_tuser);
                  error_count++;
               end
            end
            responses_seen++;
            // the sender keeps going meanwhile, so the pipeline fills and backs up
            if (responses_seen == HOLD_AT)
               hold_left = HOLD_CYCLES;
         end
         quiet = responses_seen >= QUIET_FIRST && responses_seen < QUIET_LAST;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // ends the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int full_chunks;
      int trailing;
      int choice;
      logic first_start;

      // directed: no start straight after reset, all-nines and all-zeros chunks
      queue_chunk(ascii_text("99999999"), 1'b0);
      queue_chunk(ascii_text("00000000"), 1'b0);
      // two more full chunks of nines wrap past 2^64
      queue_chunk(ascii_text("99999999"), 1'b0);
      queue_chunk(ascii_text("99999999"), 1'b0);
      queue_chunk(ascii_text("1234567/"), 1'b0);
      // already ended, digits ignored
      queue_chunk(ascii_text("99999999"), 1'b0);
      queue_chunk(ascii_text("12345678"), 1'b0);
      // first byte not a digit, byte extremes
      queue_chunk(ascii_text(":9999999"), 1'b1);
      queue_chunk('0, 1'b1);
      queue_chunk('1, 1'b1);
      queue_chunk(ascii_text("/0000000"), 1'b1);
      // partial run lengths one through six
      queue_chunk(ascii_text("7:"), 1'b1);
      queue_chunk(ascii_text("42/"), 1'b1);
      queue_chunk(ascii_text("123"), 1'b1);
      queue_chunk(ascii_text("9876x"), 1'b1);
      queue_chunk(ascii_text("31415."), 1'b1);
      queue_chunk(ascii_text("000000a"), 1'b1);
      // largest two-chunk number, then close it
      queue_chunk(ascii_text("99999999"), 1'b1);
      queue_chunk(ascii_text("99999999"), 1'b0);
      queue_chunk(ascii_text("9"), 1'b0);
      // start on a closed number reopens it
      queue_chunk(ascii_text("00000001"), 1'b1);
      queue_chunk(ascii_text("2\0"), 1'b0);

      // random: mostly well-formed numbers, some broken ones and raw noise
      while (pending_chunks.size() < RANDOM_CHUNKS) begin
         choice = $urandom_range(99);
         if (choice < 12) begin
            queue_chunk({$urandom, $urandom}, 1'($urandom_range(1)));
         end else begin
            full_chunks = $urandom_range(9) == 0 ? $urandom_range(3, 6) : $urandom_range(0, 3);
            // a missing start continues whatever came before
            first_start = choice >= 20;
            for (int k = 0; k < full_chunks; k++)
               queue_chunk(text_with_run(dacp_pkg::CHUNK_BYTES),
                           k == 0 ? first_start : 1'b0);
            // most numbers end inside a chunk, some are cut off by the next start
            if (choice < 90)
               queue_chunk(text_with_run($urandom_range(0, dacp_pkg::CHUNK_BYTES - 1)),
                           full_chunks == 0 ? first_start : 1'b0);
            trailing = $urandom_range(2);
            for (int k = 0; k < trailing; k++)
               queue_chunk(text_with_run($urandom_range(0, dacp_pkg::CHUNK_BYTES)), 1'b0);
         end
      end
      // sender waits here until every response has come back
      pending_chunks[DRAIN_AT_A].drain_first = 1'b1;
      pending_chunks[DRAIN_AT_B].drain_first = 1'b1;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_chunks.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_results.size() != 0) begin
         $error("%0d responses never arrived", expected_results.size());
         error_count++;
      end
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
